// File: rtl/cwpm_pkg.sv
`default_nettype none

package cwpm_pkg;

  // Field and accumulator widths
  localparam int W_W       = 16;  // weight, Q0.16
  localparam int V_W       = 24;  // value, Q8.16
  localparam int M_W       = 24;  // mean result, Q8.16
  localparam int WT_W      = 28;  // running weight sum
  localparam int SUM_W     = 52;  // running weighted sum, 32 fraction bits
  localparam int PROD_W    = 40;  // weight * value
  localparam int DIV_W     = WT_W + 1;  // weight sum + epsilon
  localparam int DIMCFG_W  = 7;
  localparam int EPS_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Divider: quotient bits produced one per cycle
  localparam int DIV_STEPS = M_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int MAX_DIM_DEF = 64;

  localparam logic [DIMCFG_W-1:0] DIM_RESET = 7'd64;
  localparam logic [EPS_W-1:0]    EPS_RESET = 16'd1;

  localparam logic [WT_W-1:0]  WT_MAX   = 28'hFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MAX  = 52'h7_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN  = 52'h8_0000_0000_0000;
  localparam logic [M_W-1:0]   MEAN_MAX = 24'h7F_FFFF;
  localparam logic [M_W-1:0]   MEAN_MIN = 24'h80_0000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input transfer this cycle
    logic sum_en;    // accumulate and write back
    logic abs_en;    // take magnitude of sum
    logic chk_en;    // overflow check, divider init
    logic div_en;    // one quotient bit
    logic out_load;  // load output register
  } cwpm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result
  } cwpm_status_t;

endpackage

`default_nettype wire

// File: rtl/causal_weighted_prefix_mean.sv
// Causal weighted prefix mean over a stream of value vector elements.
// Input channel s_axis: one transfer per element; tdata carries the Q0.16
// weight of the time step and the signed Q8.16 value, tuser the
// stream-start flag that clears the weight sum and all weighted sums.
// Output channel m_axis: one transfer per input, in order; tdata is the
// signed Q8.16 mean, tlast marks the last element of a time step, tuser
// flags any saturation of the mean or the accumulators.
// Config: cfg_we_i writes dim_in_use (index 0) or epsilon (index 1);
// write only while the block is idle.
// Sequence: each item passes the accept step, accumulate with
// store write-back, magnitude, overflow check, the radix-2
// restoring divider (one quotient bit per cycle), and the output load.
// The next item is taken as soon as a result sits in the output register,
// even if m_axis is stalled; a stalled result holds, and the controller
// then waits in its final step until the register frees.
// Reset: async, active low; clears sums (by fill count), position and
// output valid, and restores dim_in_use = 64, epsilon = 1. No clearing pass.
`default_nettype none

module causal_weighted_prefix_mean #(
  parameter int MAX_DIM = cwpm_pkg::MAX_DIM_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // config write port
  input  wire                              cfg_we_i,
  input  wire  [cwpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [cwpm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [cwpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [15:0] weight, [39:16] value
  input  wire  [0:0]                       s_axis_tuser,  // [0] stream_start
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [cwpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [23:0] mean_value
  output logic                             m_axis_tlast,  // last_of_step
  output logic [0:0]                       m_axis_tuser   // [0] saturated
);

  cwpm_pkg::cwpm_cmd_t    cmd;
  cwpm_pkg::cwpm_status_t status;

  // sequencer: one item at a time through the divider
  cwpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // accumulators, sum store, divider and output register
  cwpm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

// File: rtl/cwpm_ctrl.sv
`default_nettype none

module cwpm_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  cwpm_pkg::cwpm_status_t status_i,
  output cwpm_pkg::cwpm_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } cwpm_state_e;

  cwpm_state_e state_q, state_d;
  logic [cwpm_pkg::STEP_W-1:0] step_q, step_d;
  logic step_last;

  assign step_last = (step_q == cwpm_pkg::STEP_W'(cwpm_pkg::DIV_STEPS - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.abs_en = 1'b1;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.chk_en = 1'b1;
        step_d       = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_take_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> (state_q == ST_SUM))
    else $error("accepted item did not start accumulation");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !status_i.out_free) |=> (state_q == ST_DONE))
    else $error("result dropped while output register busy");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");
`endif

endmodule

`default_nettype wire

// File: rtl/cwpm_dp.sv
`default_nettype none

module cwpm_dp #(
  parameter int MAX_DIM = cwpm_pkg::MAX_DIM_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [cwpm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [cwpm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire  [cwpm_pkg::IN_DATA_W-1:0]     in_data_i,
  input  wire  [0:0]                         in_user_i,
  output logic [cwpm_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic                               out_last_o,
  output logic [0:0]                         out_user_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  input  cwpm_pkg::cwpm_cmd_t                cmd_i,
  output cwpm_pkg::cwpm_status_t             status_o
);

  localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int FILL_W = $clog2(MAX_DIM + 1);
  localparam int EXT_W  = (FILL_W > cwpm_pkg::DIMCFG_W) ? FILL_W : cwpm_pkg::DIMCFG_W;
  localparam int SUM_W  = cwpm_pkg::SUM_W;
  localparam int DIV_W  = cwpm_pkg::DIV_W;
  localparam int M_W    = cwpm_pkg::M_W;

  // Config registers
  logic [cwpm_pkg::DIMCFG_W-1:0] dim_q;
  logic [cwpm_pkg::EPS_W-1:0]    eps_q;

  // Stream state
  logic [cwpm_pkg::WT_W-1:0] wt_q, wt_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [FILL_W-1:0]         fill_q, fill_d;  // entries 0..fill-1 written since clear

  // Per-item registers
  logic [POS_W-1:0]             cur_pos_q, cur_pos;
  logic                         hit_q, hit;
  logic                         last_q, last_d;
  logic                         sat_q;
  logic                         wt_sat;
  logic signed [cwpm_pkg::PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]             rd_q;
  logic [SUM_W-1:0]             s_q, s_d;
  logic                         s_sat;
  logic [DIV_W-1:0]             div_q;
  logic                         neg_q, nz_q;
  logic [SUM_W-1:0]             mag_q;
  logic [DIV_W-1:0]             rem_q;
  logic [M_W-1:0]               quo_q;
  logic                         ovf_q;

  // Output register
  logic                    out_valid_q;
  logic [M_W-1:0]          out_mean_q, mean_d;
  logic                    out_last_q;
  logic                    out_sat_q, clip_d;

  logic [SUM_W-1:0] mem [MAX_DIM];

  // Input fields
  logic                        start;
  logic [cwpm_pkg::W_W-1:0]    w;
  logic signed [cwpm_pkg::V_W-1:0] v;
  logic signed [cwpm_pkg::PROD_W:0] prod_full;

  assign start = in_user_i[0];
  assign w     = in_data_i[cwpm_pkg::W_W-1:0];
  assign v     = $signed(in_data_i[cwpm_pkg::W_W +: cwpm_pkg::V_W]);
  assign prod_full = $signed({1'b0, w}) * v;

  // Effective dimension, clamped to 1..MAX_DIM
  logic [EXT_W-1:0]  cfg_ext, eff_ext;
  logic [FILL_W-1:0] eff_dim;

  always_comb begin
    cfg_ext = EXT_W'(dim_q);
    if (cfg_ext == '0) begin
      eff_ext = EXT_W'(1);
    end else if (cfg_ext > EXT_W'(MAX_DIM)) begin
      eff_ext = EXT_W'(MAX_DIM);
    end else begin
      eff_ext = cfg_ext;
    end
    eff_dim = FILL_W'(eff_ext);
  end

  // Position, fill and weight sum update at input transfer
  logic [POS_W-1:0]              pos_base;
  logic [FILL_W-1:0]             fill_base, pos_ext;
  logic [cwpm_pkg::WT_W-1:0]     wt_base;
  logic [cwpm_pkg::WT_W:0]       wt_sum;

  always_comb begin
    pos_base  = start ? '0 : pos_q;
    fill_base = start ? '0 : fill_q;
    wt_base   = start ? '0 : wt_q;
    // position stranded past a shrunken dimension restarts the step
    cur_pos   = (FILL_W'(pos_base) >= eff_dim) ? '0 : pos_base;
    pos_ext   = FILL_W'(cur_pos);
    last_d    = (pos_ext == eff_dim - 1'b1);
    pos_d     = last_d ? '0 : cur_pos + 1'b1;
    hit       = (pos_ext < fill_base);
    fill_d    = (pos_ext + 1'b1 > fill_base) ? pos_ext + 1'b1 : fill_base;
    wt_sum    = {1'b0, wt_base} + (cwpm_pkg::WT_W + 1)'(w);
    wt_sat    = 1'b0;
    wt_d      = wt_base;
    if (cur_pos == '0) begin
      if (wt_sum[cwpm_pkg::WT_W]) begin
        wt_d   = cwpm_pkg::WT_MAX;
        wt_sat = 1'b1;
      end else begin
        wt_d = wt_sum[cwpm_pkg::WT_W-1:0];
      end
    end
  end

  // Accumulate with saturation
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W:0]   sum_x;

  always_comb begin
    old_sum = hit_q ? rd_q : '0;
    sum_x   = {old_sum[SUM_W-1], old_sum}
            + {{(SUM_W + 1 - cwpm_pkg::PROD_W){prod_q[cwpm_pkg::PROD_W-1]}}, prod_q};
    s_sat   = (sum_x[SUM_W] != sum_x[SUM_W-1]);
    if (s_sat) begin
      s_d = sum_x[SUM_W] ? cwpm_pkg::SUM_MIN : cwpm_pkg::SUM_MAX;
    end else begin
      s_d = sum_x[SUM_W-1:0];
    end
  end

  // One restoring divide step
  logic [DIV_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, mag_q[M_W-1]};
    qbit  = (trial >= {1'b0, div_q});
  end

  // Final result with clipping
  always_comb begin
    clip_d = 1'b0;
    mean_d = quo_q;
    if (div_q == '0) begin
      if (nz_q) begin
        clip_d = 1'b1;
        mean_d = neg_q ? cwpm_pkg::MEAN_MIN : cwpm_pkg::MEAN_MAX;
      end else begin
        mean_d = '0;
      end
    end else if (neg_q) begin
      if (ovf_q || quo_q > cwpm_pkg::MEAN_MIN) begin
        clip_d = 1'b1;
        mean_d = cwpm_pkg::MEAN_MIN;
      end else begin
        mean_d = '0 - quo_q;
      end
    end else if (ovf_q || quo_q[M_W-1]) begin
      clip_d = 1'b1;
      mean_d = cwpm_pkg::MEAN_MAX;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q       <= cwpm_pkg::DIM_RESET;
      eps_q       <= cwpm_pkg::EPS_RESET;
      wt_q        <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cwpm_pkg::CFG_DIM_IN_USE: dim_q <= cfg_wdata_i[cwpm_pkg::DIMCFG_W-1:0];
          cwpm_pkg::CFG_EPSILON:    eps_q <= cfg_wdata_i[cwpm_pkg::EPS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        wt_q   <= wt_d;
        pos_q  <= pos_d;
        fill_q <= fill_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_pos_q <= cur_pos;
      hit_q     <= hit;
      last_q    <= last_d;
      sat_q     <= wt_sat;
      prod_q    <= prod_full[cwpm_pkg::PROD_W-1:0];
    end
    if (cmd_i.sum_en) begin
      s_q   <= s_d;
      sat_q <= sat_q | s_sat;
      div_q <= {1'b0, wt_q} + DIV_W'(eps_q);
    end
    if (cmd_i.abs_en) begin
      mag_q <= s_q[SUM_W-1] ? ('0 - s_q) : s_q;
      neg_q <= s_q[SUM_W-1];
      nz_q  <= (s_q != '0);
    end
    if (cmd_i.chk_en) begin
      // quotient needs more than M_W bits when mag >= div * 2^M_W
      ovf_q <= ({1'b0, mag_q[SUM_W-1:M_W]} >= div_q);
      rem_q <= {1'b0, mag_q[SUM_W-1:M_W]};
      quo_q <= '0;
    end
    if (cmd_i.div_en) begin
      rem_q <= qbit ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
      quo_q <= {quo_q[M_W-2:0], qbit};
      mag_q <= {mag_q[SUM_W-2:0], 1'b0};
    end
    if (cmd_i.out_load) begin
      out_mean_q <= mean_d;
      out_last_q <= last_q;
      out_sat_q  <= sat_q | clip_d;
    end
  end

  // Weighted sum store
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q <= mem[cur_pos];
    end
    if (cmd_i.sum_en) begin
      mem[cur_pos_q] <= s_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_mean_q;
  assign out_last_o        = out_last_q;
  assign out_user_o        = out_sat_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_DIM))
    else $error("fill count past store depth");

  a_start_clears_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && start) |=> (wt_q[cwpm_pkg::WT_W-1:cwpm_pkg::W_W] == '0))
    else $error("stream start did not clear weight sum");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_en && !ovf_q && div_q != '0) |-> (rem_q < div_q))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;

  localparam int DIM_CAP      = cwpm_pkg::MAX_DIM_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ELEMS = 420;
  localparam int SOAK_STEPS   = 20;    // full-scale steps ahead of the random tail

  localparam logic signed [cwpm_pkg::V_W-1:0] VAL_MAX = 24'h7F_FFFF;
  localparam logic signed [cwpm_pkg::V_W-1:0] VAL_MIN = 24'h80_0000;
  localparam logic [cwpm_pkg::W_W-1:0]        W_FULL  = 16'hFFFF;

  // Clip limits of the weight sum, weighted sums and the mean
  localparam longint WSUM_HI = 64'h0000_0000_0FFF_FFFF;
  localparam longint SUM_HI  = 64'h0007_FFFF_FFFF_FFFF;
  localparam longint SUM_LO  = -SUM_HI - 1;
  localparam longint MEAN_HI = 8388607;
  localparam longint MEAN_LO = -8388608;

  typedef struct packed {
    logic                            start;
    logic [cwpm_pkg::W_W-1:0]        weight;
    logic signed [cwpm_pkg::V_W-1:0] value;
  } elem_t;

  typedef struct packed {
    logic [cwpm_pkg::M_W-1:0] mean;
    logic                     last;
    logic                     sat;
  } mean_t;

  // Receiver behavior between long hold-offs
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_RANDOM,  // ready at random, with odds of two in three
    RX_SPARSE   // ready one cycle in five
  } rx_mode_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [cwpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [cwpm_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cwpm_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] weight, [39:16] value
  logic [0:0]                      s_axis_tuser  = '0;  // [0] stream_start
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cwpm_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // [23:0] mean_value
  logic                            m_axis_tlast;
  logic [0:0]                      m_axis_tuser;        // [0] saturated

  causal_weighted_prefix_mean dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Safety net: several times the slowest legal run
  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mean predictor: own copy of the registers and accumulators
  // ---------------------------------------------------------------------------
  logic [cwpm_pkg::DIMCFG_W-1:0] dim_reg = cwpm_pkg::DIM_RESET;
  logic [cwpm_pkg::EPS_W-1:0]    eps_reg = cwpm_pkg::EPS_RESET;
  longint              weight_sum = 0;
  longint              weighted_sum [DIM_CAP] = '{default: 0};
  int unsigned         elem_pos = 0;

  mean_t expected_means [$];  // one per accepted element, oldest first
  elem_t elems_to_send [$];   // filled by the stimulus, drained by the driver

  int unsigned elems_sent   = 0;
  int unsigned means_seen   = 0;
  int unsigned clipped_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned mismatches   = 0;
  int unsigned holds_asked  = 0;  // long hold-offs requested by the stimulus
  int unsigned holds_taken  = 0;  // long hold-offs started by the receiver

  // dim_in_use of 0 acts as 1, anything above the store depth as the depth
  function automatic int unsigned eff_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > DIM_CAP) return DIM_CAP;
    return dim_reg;
  endfunction

  function automatic void predict_mean(input elem_t e);
    int unsigned d;
    int unsigned p;
    longint      prod;
    longint      acc;
    longint      divisor;
    longint      q;
    logic        clip;
    mean_t       r;
    if (e.start) begin
      weight_sum = 0;
      foreach (weighted_sum[i]) weighted_sum[i] = 0;
      elem_pos = 0;
    end
    clip = 1'b0;
    d = eff_dim();
    // a position left over from a wider setting starts a new step
    p = (elem_pos >= d) ? 0 : elem_pos;
    // the weight sum grows once per step, on element zero
    if (p == 0) begin
      weight_sum += longint'(e.weight);
      if (weight_sum > WSUM_HI) begin
        weight_sum = WSUM_HI;
        clip = 1'b1;
      end
    end
    prod = longint'(e.weight) * longint'($signed(e.value));
    acc  = weighted_sum[p] + prod;
    if (acc > SUM_HI) begin
      acc  = SUM_HI;
      clip = 1'b1;
    end else if (acc < SUM_LO) begin
      acc  = SUM_LO;
      clip = 1'b1;
    end
    weighted_sum[p] = acc;
    divisor = weight_sum + longint'(eps_reg);
    if (divisor == 0) begin
      // zero divisor: sign of the sum picks the rail
      q = (acc > 0) ? MEAN_HI : ((acc < 0) ? MEAN_LO : 0);
      if (acc != 0) clip = 1'b1;
    end else begin
      q = acc / divisor;  // truncates toward zero
      if (q > MEAN_HI) begin
        q    = MEAN_HI;
        clip = 1'b1;
      end else if (q < MEAN_LO) begin
        q    = MEAN_LO;
        clip = 1'b1;
      end
    end
    r.mean = q[cwpm_pkg::M_W-1:0];
    r.last = (p == d - 1);
    r.sat  = clip;
    elem_pos = (p == d - 1) ? 0 : p + 1;
    expected_means.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps between them
  // ---------------------------------------------------------------------------
  elem_t       elem_on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_mean(elem_on_bus);
        elems_sent++;
      end
      // only move on once the offered element is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (elems_to_send.size() > 0) begin
          elem_on_bus = elems_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {elem_on_bus.value, elem_on_bus.weight};
          s_axis_tuser  <= elem_on_bus.start;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer, drives the stall pattern
  // ---------------------------------------------------------------------------
  mean_t       want;
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          $error("result with nothing expected: mean_value %0d", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = expected_means.pop_front();
          means_seen++;
          if (want.sat) clipped_seen++;
          if (m_axis_tdata !== want.mean) begin
            $error("mean_value: expected %0d, actual %0d",
                   $signed(want.mean), $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_step: expected %0b, actual %0b", want.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser[0] !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, m_axis_tuser[0]);
            mismatches++;
          end
        end
      end

      rx_tick++;
      if (holds_taken != holds_asked) begin
        // long hold-off: the block fills up and must stall its input
        holds_taken++;
        hold_left = $urandom_range(300, 500);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
          default:   m_axis_tready <= (rx_tick % 5 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_elem(input logic start, input logic [cwpm_pkg::W_W-1:0] w,
                                     input logic signed [cwpm_pkg::V_W-1:0] v);
    elem_t e;
    e.start  = start;
    e.weight = w;
    e.value  = v;
    elems_to_send.push_back(e);
  endfunction

  function automatic logic [cwpm_pkg::W_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return W_FULL;
      2:       return cwpm_pkg::W_W'($urandom_range(1, 255));
      default: return cwpm_pkg::W_W'($urandom());
    endcase
  endfunction

  function automatic logic [cwpm_pkg::V_W-1:0] pick_value();
    int s;
    s = int'($urandom_range(0, 262143)) - 131072;
    case ($urandom_range(0, 6))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return s[cwpm_pkg::V_W-1:0];  // within +-2.0
      default: return cwpm_pkg::V_W'($urandom());
    endcase
  endfunction

  // block settles: nothing queued, offered or owed, then latency slack;
  // checked mid-cycle so that the driver's updates have landed
  task automatic wait_idle();
    while (elems_to_send.size() != 0 || expected_means.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cwpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cwpm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cwpm_pkg::CFG_DIM_IN_USE) dim_reg = data[cwpm_pkg::DIMCFG_W-1:0];
    else eps_reg = data[cwpm_pkg::EPS_W-1:0];
    reg_writes++;
  endtask

  // Mostly well-formed streams: a start, then steps whose elements share a
  // weight. Noise: odd weights inside a step, starts in the middle of a step.
  // Phases end anywhere, so a narrower setting can find a stale position.
  task automatic random_phase(input int unsigned count);
    int unsigned   d;
    int unsigned   pos;
    logic          st;
    logic [cwpm_pkg::W_W-1:0] w;
    logic [cwpm_pkg::W_W-1:0] w_elem;
    d   = eff_dim();
    pos = 0;
    st  = ($urandom_range(0, 4) != 0);
    w   = pick_weight();
    for (int k = 0; k < count; k++) begin
      if (pos == 0 && k > 0) w = pick_weight();
      w_elem = ($urandom_range(0, 19) == 0) ? pick_weight() : w;
      if ($urandom_range(0, 39) == 0) begin
        st  = 1'b1;
        pos = 0;
      end
      queue_elem(st, w_elem, pick_value());
      st  = 1'b0;
      pos = (pos + 1 == d) ? 0 : pos + 1;
      if (pos == 0 && $urandom_range(0, 9) == 0) st = 1'b1;
    end
  endtask

  int unsigned random_queued = 0;
  int unsigned phase_elems;
  bit          hold_done = 1'b0;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (64 wide, epsilon 1): zero element, then both rails
    queue_elem(1'b1, 16'd0, 24'sd0);
    queue_elem(1'b0, W_FULL, VAL_MAX);
    queue_elem(1'b0, W_FULL, VAL_MIN);
    wait_idle();

    // Four wide, no epsilon: zero divisor with zero, negative and positive
    // sums, then a step whose weights change element to element
    write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd4);
    write_reg(cwpm_pkg::CFG_EPSILON, 16'd0);
    queue_elem(1'b1, 16'd0, 24'sd123);
    queue_elem(1'b0, 16'd300, -24'sd5);
    queue_elem(1'b0, 16'd7, 24'sd9);
    queue_elem(1'b0, 16'd0, 24'sd0);
    queue_elem(1'b0, W_FULL, 24'sd65536);
    queue_elem(1'b0, 16'd32768, -24'sd65536);
    queue_elem(1'b0, 16'd1, 24'sd1);
    queue_elem(1'b0, W_FULL, VAL_MAX);
    queue_elem(1'b0, 16'd100, -24'sd1);
    queue_elem(1'b0, 16'd100, 24'sd2);  // leaves the position at two
    wait_idle();

    // Width 0 (upper write bits set) acts as 1 and finds a stale position;
    // largest epsilon
    write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'hFF80);
    write_reg(cwpm_pkg::CFG_EPSILON, 16'hFFFF);
    queue_elem(1'b0, W_FULL, VAL_MIN);
    queue_elem(1'b0, W_FULL, VAL_MAX);
    queue_elem(1'b1, 16'd12345, -24'sd77);
    wait_idle();

    // Width 127 acts as the store depth; alternating bit patterns
    write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'h007F);
    write_reg(cwpm_pkg::CFG_EPSILON, 16'd1);
    queue_elem(1'b1, W_FULL, VAL_MAX);
    queue_elem(1'b0, W_FULL, VAL_MAX);
    queue_elem(1'b0, 16'd0, VAL_MIN);
    queue_elem(1'b0, 16'h5555, 24'hAA_AAAA);
    queue_elem(1'b0, 16'hAAAA, 24'h55_5555);
    wait_idle();

    // Random phases, each under its own settings
    while (random_queued < RANDOM_ELEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd0);
          1:       write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd1);
          2:       write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd64);
          3:       write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd127);
          4:       write_reg(cwpm_pkg::CFG_DIM_IN_USE, cwpm_pkg::CFG_DATA_W'($urandom()));
          default: write_reg(cwpm_pkg::CFG_DIM_IN_USE,
                             cwpm_pkg::CFG_DATA_W'($urandom_range(2, 8)));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(cwpm_pkg::CFG_EPSILON, 16'd0);
          1:       write_reg(cwpm_pkg::CFG_EPSILON, 16'd1);
          2:       write_reg(cwpm_pkg::CFG_EPSILON, 16'hFFFF);
          default: write_reg(cwpm_pkg::CFG_EPSILON, cwpm_pkg::CFG_DATA_W'($urandom()));
        endcase
      end
      phase_elems = (eff_dim() > 16) ? $urandom_range(40, 150) : $urandom_range(15, 90);
      if (phase_elems > RANDOM_ELEMS - random_queued)
        phase_elems = RANDOM_ELEMS - random_queued;
      random_phase(phase_elems);
      random_queued += phase_elems;
      if (!hold_done && phase_elems >= 40) begin
        hold_done = 1'b1;
        holds_asked++;
      end
      wait_idle();
    end

    // Full-scale steps, two wide: the two weighted sums run far apart, one
    // high and one low; then random steps on top of them
    write_reg(cwpm_pkg::CFG_DIM_IN_USE, 16'd2);
    write_reg(cwpm_pkg::CFG_EPSILON, 16'hFFFF);
    for (int s = 0; s < SOAK_STEPS; s++) begin
      queue_elem(s == 0, W_FULL, VAL_MAX);
      queue_elem(1'b0, W_FULL, VAL_MIN);
    end
    for (int s = 0; s < 30; s++) begin
      queue_elem(1'b0, pick_weight(), pick_value());
      queue_elem(1'b0, pick_weight(), pick_value());
    end
    holds_asked++;
    wait_idle();

    $display("covered %0d element transfers, %0d means checked, %0d of them clipped",
             elems_sent, means_seen, clipped_seen);
    $display("%0d register writes across the phases, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/cwpm_pkg.sv
rtl/cwpm_ctrl.sv
rtl/cwpm_dp.sv
rtl/causal_weighted_prefix_mean.sv
tb/testbench.sv
